/* hw/rtl/assert_macros.svh */
// Assertion helpers used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed: implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed: next-cycle implication");

`endif

/* hw/rtl/hcbd_pkg.sv */
`default_nettype none

package hcbd_pkg;

  // Parser modes
  typedef enum logic [1:0] {
    MODE_SIZE = 2'd0,
    MODE_BODY = 2'd1,
    MODE_SKIP = 2'd2,
    MODE_DONE = 2'd3
  } mode_t;

  // Result status codes
  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_COMPLETE = 3'd1;
  localparam logic [2:0] ST_TRUNC    = 3'd2;
  localparam logic [2:0] ST_LONG     = 3'd3;
  localparam logic [2:0] ST_OVERFLOW = 3'd4;
  localparam logic [2:0] ST_EOF_LINE = 3'd5;

  // Characters of interest
  localparam logic [7:0] CHR_TAB = 8'h09;
  localparam logic [7:0] CHR_LF  = 8'h0A;
  localparam logic [7:0] CHR_VT  = 8'h0B;
  localparam logic [7:0] CHR_FF  = 8'h0C;
  localparam logic [7:0] CHR_CR  = 8'h0D;
  localparam logic [7:0] CHR_SP  = 8'h20;

  localparam int unsigned SIZE_W = 63;

  // Parser state, apart from the line length whose width is a parameter
  typedef struct packed {
    mode_t             mode;
    logic [SIZE_W-1:0] rem;
    logic [SIZE_W-1:0] acc;
    logic              hex_ended;
    logic              saw_cr;
    logic              digit_seen;
    logic [2:0]        err;
  } hcbd_state_t;

  // One result item
  typedef struct packed {
    logic [7:0] out_byte;
    logic       body_valid;
    logic [2:0] status;
  } hcbd_res_t;

endpackage

`default_nettype wire

/* hw/rtl/hcbd_if.sv */
`default_nettype none

// Input channel: one raw byte or an end-of-stream marker per request
interface hcbd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       stream_end;

  modport source (output valid, output in_byte, output stream_end, input ready);
  modport sink   (input valid, input in_byte, input stream_end, output ready);
endinterface

// Result channel: one decoded result per request
interface hcbd_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       body_valid;
  logic [2:0] status;

  modport source (output valid, output out_byte, output body_valid, output status,
                  input ready);
  modport sink   (input valid, input out_byte, input body_valid, input status,
                  output ready);
endinterface

`default_nettype wire

/* hw/rtl/http_chunked_body_decoder_top.sv */
`default_nettype none

// HTTP/1.1 chunked body decoder. Each request on in_chan carries one raw byte
// (or an end-of-stream marker) and produces exactly one result on out_chan in the
// next cycle: a body byte with body_valid set, or a status only. A new byte is
// taken every cycle while the result register is empty or being drained; the
// rate is one byte per cycle, set by the combinational update of the parser
// state (hex shift-add of the size line, 63-bit decrement of the chunk count).
// Errors (truncation, line too long, size overflow, end inside a size line)
// stick until reset. LINE_BYTES bounds the content length of a size line.
module http_chunked_body_decoder_top
  import hcbd_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 256
) (
  input  wire             clk,
  input  wire             rst_n,
  hcbd_in_if.sink         in_chan,
  hcbd_out_if.source      out_chan
);

  localparam int unsigned LW = $clog2(LINE_BYTES);

  hcbd_state_t   st_r;
  hcbd_state_t   st_nxt;
  logic [LW-1:0] len_r;
  logic [LW-1:0] len_nxt;
  hcbd_res_t     res_r;
  hcbd_res_t     res_nxt;
  logic          out_vld_r;
  logic          in_acc;

  // Accept while the result slot is empty or emptying this cycle
  assign in_chan.ready = !out_vld_r || out_chan.ready;
  assign in_acc        = in_chan.valid && in_chan.ready;

  hcbd_step #(
    .LINE_BYTES (LINE_BYTES)
  ) u_step (
    .cur        (st_r),
    .len        (len_r),
    .in_byte    (in_chan.in_byte),
    .stream_end (in_chan.stream_end),
    .nxt        (st_nxt),
    .len_nxt    (len_nxt),
    .res        (res_nxt)
  );

  // Parser state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r.mode       <= MODE_SIZE;
      st_r.rem        <= '0;
      st_r.acc        <= '0;
      st_r.hex_ended  <= 1'b0;
      st_r.saw_cr     <= 1'b0;
      st_r.digit_seen <= 1'b0;
      st_r.err        <= ST_OK;
      len_r           <= '0;
    end else if (in_acc) begin
      st_r  <= st_nxt;
      len_r <= len_nxt;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (in_acc) begin
      out_vld_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      res_r <= res_nxt;
    end
  end

  assign out_chan.valid      = out_vld_r;
  assign out_chan.out_byte   = res_r.out_byte;
  assign out_chan.body_valid = res_r.body_valid;
  assign out_chan.status     = res_r.status;

endmodule

`default_nettype wire

/* hw/rtl/hcbd_step.sv */
`default_nettype none

module hcbd_step
  import hcbd_pkg::*;
#(
  parameter int unsigned LINE_BYTES = 256
) (
  input  hcbd_state_t                      cur,
  input  logic [$clog2(LINE_BYTES)-1:0]    len,
  input  logic [7:0]                       in_byte,
  input  logic                             stream_end,
  output hcbd_state_t                      nxt,
  output logic [$clog2(LINE_BYTES)-1:0]    len_nxt,
  output hcbd_res_t                        res
);

  localparam int unsigned LW  = $clog2(LINE_BYTES);
  localparam int unsigned LSW = LW + 2;

  logic              is_cr;
  logic              is_lf;
  logic              is_blank;
  logic              is_digit;
  logic [3:0]        digit;
  logic              line_end;
  logic [1:0]        n_count;
  logic [LSW-1:0]    len_sum;
  logic              long_err;
  logic              ovf_err;
  logic [SIZE_W-1:0] rem_dec;

  // Character classes and size line checks
  always_comb begin
    is_cr    = (in_byte == CHR_CR);
    is_lf    = (in_byte == CHR_LF);
    is_blank = (in_byte == CHR_SP) || (in_byte == CHR_TAB) || is_cr || is_lf ||
               (in_byte == CHR_VT) || (in_byte == CHR_FF);
    is_digit = 1'b1;
    digit    = 4'd0;
    if (in_byte >= "0" && in_byte <= "9") begin
      digit = 4'(in_byte - 8'("0"));
    end else if (in_byte >= "a" && in_byte <= "f") begin
      digit = 4'(in_byte - 8'("a") + 8'd10);
    end else if (in_byte >= "A" && in_byte <= "F") begin
      digit = 4'(in_byte - 8'("A") + 8'd10);
    end else begin
      is_digit = 1'b0;
    end
    line_end = cur.saw_cr && is_lf;
    // a pending CR that is not part of CRLF counts now, plus this byte unless CR
    n_count  = {1'b0, cur.saw_cr} + {1'b0, !is_cr};
    len_sum  = LSW'(len) + LSW'(n_count);
    long_err = (n_count != 2'd0) && (len_sum >= LSW'(LINE_BYTES));
    ovf_err  = !cur.hex_ended && is_digit && (cur.acc[SIZE_W-1:SIZE_W-4] != 4'd0);
    rem_dec  = cur.rem - SIZE_W'(1);
  end

  // Next state
  always_comb begin
    nxt     = cur;
    len_nxt = len;
    if (cur.err != ST_OK) begin
      // sticky error: hold everything
    end else if (stream_end) begin
      if (cur.mode == MODE_SIZE) begin
        nxt.err = ST_EOF_LINE;
      end else if (cur.mode != MODE_DONE) begin
        nxt.err = ST_TRUNC;
      end
    end else begin
      unique case (cur.mode)
        MODE_SIZE: begin
          if (line_end) begin
            nxt.mode       = (cur.acc == '0) ? MODE_DONE : MODE_BODY;
            nxt.rem        = cur.acc;
            nxt.acc        = '0;
            nxt.hex_ended  = 1'b0;
            nxt.saw_cr     = 1'b0;
            nxt.digit_seen = 1'b0;
            len_nxt        = '0;
          end else if (long_err) begin
            nxt.err = ST_LONG;
          end else if (ovf_err) begin
            nxt.err = ST_OVERFLOW;
          end else begin
            len_nxt    = len_sum[LW-1:0];
            nxt.saw_cr = is_cr;
            if (!cur.hex_ended) begin
              if (is_digit) begin
                nxt.acc        = {cur.acc[SIZE_W-5:0], digit};
                nxt.digit_seen = 1'b1;
              end else if (cur.digit_seen || !is_blank) begin
                nxt.hex_ended = 1'b1;
              end
            end
          end
        end
        MODE_BODY: begin
          if (rem_dec == '0) begin
            nxt.mode = MODE_SKIP;
            nxt.rem  = SIZE_W'(2);
          end else begin
            nxt.rem = rem_dec;
          end
        end
        MODE_SKIP: begin
          nxt.rem = rem_dec;
          if (rem_dec == '0) begin
            nxt.mode       = MODE_SIZE;
            nxt.acc        = '0;
            nxt.hex_ended  = 1'b0;
            nxt.saw_cr     = 1'b0;
            nxt.digit_seen = 1'b0;
            len_nxt        = '0;
          end
        end
        MODE_DONE: begin
          // trailers are dropped
        end
        default: begin
          nxt.mode = MODE_DONE;
        end
      endcase
    end
  end

  // Result
  always_comb begin
    res.out_byte   = 8'd0;
    res.body_valid = 1'b0;
    res.status     = ST_OK;
    if (cur.err != ST_OK) begin
      res.status = cur.err;
    end else if (stream_end) begin
      unique case (cur.mode)
        MODE_DONE: res.status = ST_COMPLETE;
        MODE_SIZE: res.status = ST_EOF_LINE;
        default:   res.status = ST_TRUNC;
      endcase
    end else begin
      unique case (cur.mode)
        MODE_SIZE: begin
          if (line_end) begin
            res.status = (cur.acc == '0) ? ST_COMPLETE : ST_OK;
          end else if (long_err) begin
            res.status = ST_LONG;
          end else if (ovf_err) begin
            res.status = ST_OVERFLOW;
          end
        end
        MODE_BODY: begin
          res.out_byte   = in_byte;
          res.body_valid = 1'b1;
        end
        MODE_DONE: res.status = ST_COMPLETE;
        default:   res.status = ST_OK;
      endcase
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/hcbd_checker.sv */
`default_nettype none

`include "assert_macros.svh"

module hcbd_checker
  import hcbd_pkg::*;
(
  input wire       clk,
  input wire       rst_n,
  input wire       in_valid,
  input wire       in_ready,
  input wire       out_valid,
  input wire       out_ready,
  input wire [7:0] out_byte,
  input wire       body_valid,
  input wire [2:0] status
);

  logic       in_acc;
  logic       out_acc;
  logic       is_err;
  logic       err_seen_r;
  logic [2:0] err_code_r;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;
  assign is_err  = (status == ST_TRUNC) || (status == ST_LONG) ||
                   (status == ST_OVERFLOW) || (status == ST_EOF_LINE);

  // Remember the first error delivered
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      err_seen_r <= 1'b0;
      err_code_r <= ST_OK;
    end else if (out_acc && is_err && !err_seen_r) begin
      err_seen_r <= 1'b1;
      err_code_r <= status;
    end
  end

  // A stalled result stays offered
  `ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid)
  // Every accepted request shows a result in the next cycle
  `ASSERT_NEXT(a_in_to_out, clk, rst_n, in_acc, out_valid)
  // Body bytes only come with an ok status
  `ASSERT_IMPL(a_body_ok, clk, rst_n, out_valid && body_valid, status == ST_OK)
  // Non-body results carry a zero byte
  `ASSERT_IMPL(a_zero_byte, clk, rst_n, out_valid && !body_valid, out_byte == 8'd0)
  // Errors stick
  `ASSERT_IMPL(a_sticky, clk, rst_n, out_acc && err_seen_r,
               (status == err_code_r) && !body_valid)

endmodule

bind http_chunked_body_decoder_top hcbd_checker u_hcbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_chan.valid),
  .in_ready   (in_chan.ready),
  .out_valid  (out_chan.valid),
  .out_ready  (out_chan.ready),
  .out_byte   (out_chan.out_byte),
  .body_valid (out_chan.body_valid),
  .status     (out_chan.status)
);

`default_nettype wire

/* test/tb.sv */
`timescale 1ns / 1ps

module tb;
  import hcbd_pkg::*;

  localparam int unsigned LINE_LIMIT   = 256;
  localparam int unsigned RAND_BYTES   = 1200;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned DRAIN_CYCLES = 8;

  // One upstream request: a raw byte or the end-of-stream marker
  typedef struct packed {
    logic [7:0] data;
    logic       eos;
  } raw_req_t;

  // How the stream is closed; errors stick, so only one per run
  typedef enum int unsigned {
    END_DONE, END_HEX_PREFIX, END_SIGN, END_LONG,
    END_OVERFLOW, END_TRUNC_BODY, END_TRUNC_SKIP, END_EOF_LINE
  } finale_t;

  logic clk = 1'b0;
  logic rst_n;

  hcbd_in_if  in_chan ();
  hcbd_out_if out_chan ();

  http_chunked_body_decoder_top #(
    .LINE_BYTES(LINE_LIMIT)
  ) u_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_chan (in_chan),
    .out_chan(out_chan)
  );

  always #5 clk = ~clk;

  raw_req_t   raw_q[$];
  hcbd_res_t  decoded_q[$];
  raw_req_t   next_req;
  hcbd_res_t  want_r, got_r;
  int unsigned n_taken = 0;
  int unsigned n_planned = 1;
  int unsigned bad_count = 0;
  int unsigned quiet_cycles = 0;

  // Decoder state as predicted
  mode_t       dec_mode   = MODE_SIZE;
  logic [62:0] chunk_left = '0;
  logic [62:0] size_val   = '0;
  int unsigned line_len   = 0;
  logic        hex_done   = 1'b0;
  logic        cr_pending = 1'b0;
  logic        have_digit = 1'b0;
  logic [2:0]  held_err   = ST_OK;

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  function automatic void restart_line();
    size_val   = '0;
    line_len   = 0;
    hex_done   = 1'b0;
    cr_pending = 1'b0;
    have_digit = 1'b0;
  endfunction

  function automatic logic [2:0] count_line_byte();
    if (line_len + 1 >= LINE_LIMIT) return ST_LONG;
    line_len++;
    return ST_OK;
  endfunction

  // Fold one size line character into the chunk length
  function automatic logic [2:0] hex_take(input logic [7:0] c);
    logic [4:0] d;
    d = 5'd16;
    if (hex_done) return ST_OK;
    if (c >= "0" && c <= "9") d = 5'(c - "0");
    else if (c >= "a" && c <= "f") d = 5'(c - "a" + 8'd10);
    else if (c >= "A" && c <= "F") d = 5'(c - "A" + 8'd10);
    if (d < 5'd16) begin
      if (size_val[62:59] != '0) return ST_OVERFLOW;
      size_val   = {size_val[58:0], d[3:0]};
      have_digit = 1'b1;
      return ST_OK;
    end
    // leading blanks are skipped, anything else ends the number
    if (!have_digit && (c == CHR_SP || c == CHR_TAB || c == CHR_CR || c == CHR_LF ||
                        c == CHR_VT || c == CHR_FF))
      return ST_OK;
    hex_done = 1'b1;
    return ST_OK;
  endfunction

  function automatic logic [2:0] take_line_byte(input logic [7:0] c);
    logic [2:0] e;
    if (c == CHR_CR) begin
      cr_pending = 1'b1;
      return hex_take(c);
    end
    e = count_line_byte();
    if (e != ST_OK) return e;
    return hex_take(c);
  endfunction

  function automatic hcbd_res_t decode_step(input logic [7:0] c, input logic eos);
    hcbd_res_t  r;
    logic [2:0] e;
    r = '0;
    if (held_err != ST_OK) begin
      r.status = held_err;
      return r;
    end
    if (eos) begin
      if (dec_mode == MODE_DONE) begin
        r.status = ST_COMPLETE;
      end else begin
        held_err = (dec_mode == MODE_SIZE) ? ST_EOF_LINE : ST_TRUNC;
        r.status = held_err;
      end
      return r;
    end
    case (dec_mode)
      MODE_SIZE: begin
        e = ST_OK;
        if (cr_pending && c == CHR_LF) begin
          // CR LF closes the size line
          if (size_val == '0) begin
            dec_mode = MODE_DONE;
            r.status = ST_COMPLETE;
          end else begin
            dec_mode   = MODE_BODY;
            chunk_left = size_val;
          end
          restart_line();
        end else begin
          // a CR not followed by LF is line content
          if (cr_pending) begin
            cr_pending = 1'b0;
            e = count_line_byte();
          end
          if (e == ST_OK) e = take_line_byte(c);
          if (e != ST_OK) begin
            held_err = e;
            r.status = e;
          end
        end
      end
      MODE_BODY: begin
        r.out_byte   = c;
        r.body_valid = 1'b1;
        chunk_left   = chunk_left - 1'b1;
        if (chunk_left == '0) begin
          dec_mode   = MODE_SKIP;
          chunk_left = 63'd2;
        end
      end
      MODE_SKIP: begin
        chunk_left = chunk_left - 1'b1;
        if (chunk_left == '0) begin
          dec_mode = MODE_SIZE;
          restart_line();
        end
      end
      default: r.status = ST_COMPLETE;
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Stream building
  // ---------------------------------------------------------------------------

  task automatic push_raw(input logic [7:0] b);
    raw_q.push_back('{data: b, eos: 1'b0});
  endtask

  task automatic push_eos();
    raw_q.push_back('{data: 8'($urandom_range(0, 255)), eos: 1'b1});
  endtask

  task automatic push_text(input string s);
    for (int i = 0; i < s.len(); i++) push_raw(s[i]);
  endtask

  task automatic push_line_end();
    push_raw(CHR_CR);
    push_raw(CHR_LF);
  endtask

  // Random byte that cannot start a line end
  function automatic logic [7:0] rand_text_byte(input bit no_lf);
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == CHR_CR || (no_lf && b == CHR_LF));
    return b;
  endfunction

  function automatic logic [7:0] rand_blank();
    case ($urandom_range(0, 4))
      0:       return CHR_SP;
      1:       return CHR_TAB;
      2:       return CHR_VT;
      3:       return CHR_FF;
      default: return CHR_LF;
    endcase
  endfunction

  task automatic push_hex(input logic [62:0] v, input bit upper);
    logic [63:0] w;
    logic [3:0]  nib;
    bit          started;
    w = {1'b0, v};
    started = 1'b0;
    for (int i = 15; i >= 0; i--) begin
      nib = w[i*4 +: 4];
      if (nib != 4'd0 || started || i == 0) begin
        started = 1'b1;
        if (nib < 4'd10) push_raw(8'h30 + nib);
        else push_raw((upper ? 8'h41 : 8'h61) + nib - 8'd10);
      end
    end
  endtask

  // Well-formed chunk with random framing noise and random payload
  task automatic add_random_chunk();
    int unsigned sz, roll;
    roll = $urandom_range(0, 99);
    if (roll < 88) sz = $urandom_range(1, 24);
    else if (roll < 98) sz = $urandom_range(25, 120);
    else sz = $urandom_range(256, 400);
    // leading blanks, sometimes a lone CR among them
    if ($urandom_range(0, 3) == 0) begin
      repeat ($urandom_range(1, 3)) push_raw(rand_blank());
      if ($urandom_range(0, 3) == 0) begin
        push_raw(CHR_CR);
        push_raw(CHR_SP);
      end
    end
    repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0) push_raw("0");
    push_hex(63'(sz), 1'($urandom_range(0, 1)));
    // chunk extension with arbitrary bytes
    case ($urandom_range(0, 3))
      0: begin
        push_raw(";");
        repeat ($urandom_range(0, 12)) begin
          if ($urandom_range(0, 9) == 0) begin
            push_raw(CHR_CR);
            push_raw(rand_text_byte(1'b1));
          end else begin
            push_raw(rand_text_byte(1'b0));
          end
        end
      end
      1: begin
        push_raw($urandom_range(0, 1) ? CHR_SP : CHR_TAB);
        push_text(";x=Ab9");
      end
      default: ;
    endcase
    push_line_end();
    repeat (sz) push_raw(8'($urandom_range(0, 255)));
    // the two trailing bytes are not checked by the block
    if ($urandom_range(0, 4) != 0) begin
      push_line_end();
    end else begin
      push_raw(8'($urandom_range(0, 255)));
      push_raw(8'($urandom_range(0, 255)));
    end
  endtask

  // ---------------------------------------------------------------------------
  // Idle percentages per phase of the run
  // ---------------------------------------------------------------------------

  function automatic int unsigned send_gap_pct();
    if (n_taken < n_planned / 3) return 35;
    if (n_taken < 2 * n_planned / 3) return 84;
    return 0;
  endfunction

  function automatic int unsigned drain_stall_pct();
    if (n_taken < n_planned / 3) return 84;
    if (n_taken < 2 * n_planned / 3) return 35;
    return 0;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: presents queued requests, predicts each accepted one
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_chan.valid <= 1'b0;
    end else begin
      if (in_chan.valid && in_chan.ready) begin
        decoded_q.push_back(decode_step(in_chan.in_byte, in_chan.stream_end));
        n_taken++;
      end
      if (!in_chan.valid || in_chan.ready) begin
        if (raw_q.size() != 0 && $urandom_range(0, 99) >= send_gap_pct()) begin
          next_req = raw_q.pop_front();
          in_chan.valid      <= 1'b1;
          in_chan.in_byte    <= next_req.data;
          in_chan.stream_end <= next_req.eos;
        end else begin
          in_chan.valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: checks each accepted result against the oldest prediction
  // ---------------------------------------------------------------------------
  task automatic note_fault(input string why, input hcbd_res_t exp_r,
                            input hcbd_res_t act_r);
    bad_count++;
    if (bad_count <= 10)
      $display("%0t %s: expected byte=%02h valid=%0d status=%0d, got byte=%02h valid=%0d status=%0d",
               $realtime, why, exp_r.out_byte, exp_r.body_valid, exp_r.status,
               act_r.out_byte, act_r.body_valid, act_r.status);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_chan.ready <= 1'b0;
    end else begin
      if (out_chan.valid && out_chan.ready) begin
        got_r = {out_chan.out_byte, out_chan.body_valid, out_chan.status};
        if (decoded_q.size() == 0) begin
          note_fault("result with none pending", '0, got_r);
        end else begin
          want_r = decoded_q.pop_front();
          if (got_r.out_byte !== want_r.out_byte || got_r.body_valid !== want_r.body_valid ||
              got_r.status !== want_r.status)
            note_fault("result mismatch", want_r, got_r);
        end
      end
      out_chan.ready <= ($urandom_range(0, 99) >= drain_stall_pct());
    end
  end

  // Watchdog on cycles with no request moving on either side
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus and end of run
  // ---------------------------------------------------------------------------
  initial begin
    finale_t     finale;
    int unsigned head_len;
    rst_n              = 1'b0;
    in_chan.valid      = 1'b0;
    in_chan.in_byte    = '0;
    in_chan.stream_end = 1'b0;
    out_chan.ready     = 1'b0;

    // blanks before the size, blank after it, lone CR in an extension
    push_raw(CHR_VT);
    push_raw(CHR_FF);
    push_raw(CHR_LF);
    push_raw(CHR_SP);
    push_raw("3");
    push_raw(CHR_SP);
    push_text(";e");
    push_raw(CHR_CR);
    push_raw("z");
    push_line_end();
    push_raw(8'h00);
    push_raw(8'hFF);
    push_raw(8'h80);
    // trailing pair that is not CR LF
    push_raw(8'hFF);
    push_raw(8'h00);
    // lone CR before the digits, leading zero
    push_raw(CHR_CR);
    push_raw(CHR_SP);
    push_text("01");
    push_line_end();
    push_raw(8'h7F);
    push_line_end();

    // size line one byte short of the length limit
    push_text("1;");
    repeat (LINE_LIMIT - 3) push_raw(rand_text_byte(1'b0));
    push_line_end();
    push_raw(8'($urandom_range(0, 255)));
    push_line_end();

    head_len = raw_q.size();
    while (raw_q.size() < head_len + RAND_BYTES) add_random_chunk();

    finale = finale_t'($urandom_range(0, 7));
    case (finale)
      END_DONE: begin
        repeat ($urandom_range(0, 2)) push_raw("0");
        push_raw("0");
        if ($urandom_range(0, 1)) push_text(";last");
        push_line_end();
        push_text("X-Check: ");
        repeat (3) push_raw(rand_text_byte(1'b1));
        push_line_end();
        push_line_end();
        repeat ($urandom_range(1, 4)) push_raw(8'($urandom_range(0, 255)));
      end
      END_HEX_PREFIX: begin
        push_text("0x1A");
        push_line_end();
        push_raw(8'($urandom_range(0, 255)));
      end
      END_SIGN: begin
        push_text("-5");
        push_line_end();
      end
      END_LONG: begin
        push_text("a;");
        repeat (LINE_LIMIT + 40) push_raw(rand_text_byte(1'b0));
      end
      END_OVERFLOW: begin
        case ($urandom_range(0, 2))
          0:       push_text("8000000000000000");
          1:       push_text("FFFFffffFFFFffff");
          default: push_text("10000000000000000");
        endcase
        push_line_end();
      end
      END_TRUNC_BODY: begin
        // largest size that fits
        if ($urandom_range(0, 1)) push_text("7FFFFFFFFFFFFFFF");
        else push_text("7fffffffffffffff");
        push_line_end();
        repeat ($urandom_range(0, 5)) push_raw(8'($urandom_range(0, 255)));
      end
      END_TRUNC_SKIP: begin
        push_raw("2");
        push_line_end();
        repeat (3) push_raw(8'($urandom_range(0, 255)));
      end
      default: begin
        push_text("1f");
      end
    endcase
    push_eos();
    repeat ($urandom_range(1, 4)) begin
      if ($urandom_range(0, 1)) push_eos();
      else push_raw(8'($urandom_range(0, 255)));
    end
    n_planned = raw_q.size();

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    while (raw_q.size() != 0 || in_chan.valid || decoded_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (bad_count == 0)
      $display("TEST PASSED");
    else
      $display("TEST FAILED");
    $finish;
  end

endmodule
